[rtl/lcra_pkg.sv]
// Shared constants, operation codes and controller/datapath link types
// for the load-cell ring average block. No dependencies.
package lcra_pkg;

  localparam int DEPTH    = 16;
  localparam int SAMPLE_W = 24;
  localparam int MS_W     = 16;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int TOTAL_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int CNT_W    = $clog2(TOTAL_W);

  localparam logic [MS_W-1:0] PERIOD_RESET = MS_W'(100);

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_SLEEP  = 2'd2;
  localparam logic [OP_W-1:0] OP_WAKE   = 2'd3;

  typedef struct packed {
    logic tick;         // advance elapsed time
    logic sleep;        // enter power-down
    logic wake;         // leave power-down
    logic take_sample;  // capture the incoming sample
    logic commit;       // write ring, update total, fill and slot
    logic div_load;     // start the divider from the running total
    logic div_step;     // one quotient bit
    logic div_fix;      // apply sign, store the mean
    logic load_out;     // fill the output register
    logic out_updated;  // updated flag for the output register
  } cmd_t;

  typedef struct packed {
    logic asleep;
    logic due;          // elapsed time reached the report period
    logic div_last;     // current divider step is the final one
  } sts_t;

endpackage

[rtl/lcra_dp.sv]
// Datapath of the load-cell ring average: sample ring, running total,
// elapsed-time counter, serial divider and output register. Uses lcra_pkg.
module lcra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lcra_pkg::cmd_t                cmd,
  output lcra_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [lcra_pkg::MS_W-1:0]     cfg_wdata,
  input  logic signed [lcra_pkg::SAMPLE_W-1:0] sample,
  output logic                          updated,
  output logic signed [lcra_pkg::SAMPLE_W-1:0] average
);

  logic signed [lcra_pkg::SAMPLE_W-1:0] ring [lcra_pkg::DEPTH];
  logic signed [lcra_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [lcra_pkg::SAMPLE_W-1:0] sample_reg;
  logic [lcra_pkg::SLOT_W-1:0]          write_slot;
  logic [lcra_pkg::FILL_W-1:0]          fill_count;
  logic signed [lcra_pkg::TOTAL_W-1:0]  running_total;
  logic signed [lcra_pkg::TOTAL_W-1:0]  total_next;
  logic [lcra_pkg::MS_W-1:0]            ms_since_report;
  logic [lcra_pkg::MS_W-1:0]            report_period;
  logic                                 asleep;
  logic signed [lcra_pkg::SAMPLE_W-1:0] published_mean;
  logic                                 full;

  logic [lcra_pkg::TOTAL_W-1:0] quo;
  logic [lcra_pkg::TOTAL_W-1:0] quo_signed;
  logic [lcra_pkg::FILL_W-1:0]  rem;
  logic [lcra_pkg::FILL_W:0]    rem_shift;
  logic [lcra_pkg::FILL_W:0]    rem_diff;
  logic [lcra_pkg::CNT_W-1:0]   div_cnt;
  logic                         neg;

  assign full = (fill_count == lcra_pkg::FILL_W'(lcra_pkg::DEPTH));

  always_comb begin
    total_next = running_total
               + lcra_pkg::TOTAL_W'(sample_reg)
               - (full ? lcra_pkg::TOTAL_W'(rd_data) : '0);
  end

  // Ring: one write and one registered read per cycle, both at write_slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ring[write_slot] <= sample_reg;
    end
    rd_data <= ring[write_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      sample_reg <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      fill_count      <= '0;
      running_total   <= '0;
      ms_since_report <= '1;
      asleep          <= 1'b0;
      report_period   <= lcra_pkg::PERIOD_RESET;
      published_mean  <= '0;
    end else begin
      if (cfg_we) begin
        report_period <= cfg_wdata;
      end
      if (cmd.sleep) begin
        asleep <= 1'b1;
      end else if (cmd.wake) begin
        asleep <= 1'b0;
      end
      if (cmd.tick && (ms_since_report != '1)) begin
        ms_since_report <= ms_since_report + 1'b1;
      end
      if (cmd.commit) begin
        running_total <= total_next;
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
        if (write_slot == lcra_pkg::SLOT_W'(lcra_pkg::DEPTH - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
        if (sts.due) begin
          ms_since_report <= '0;
        end
      end
      if (cmd.div_fix) begin
        published_mean <= quo_signed[lcra_pkg::SAMPLE_W-1:0];
      end
    end
  end

  // Restoring divider: magnitude of total by fill count, one bit per cycle
  assign rem_shift  = {rem, quo[lcra_pkg::TOTAL_W-1]};
  assign rem_diff   = rem_shift - {1'b0, fill_count};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg     <= running_total[lcra_pkg::TOTAL_W-1];
      quo     <= running_total[lcra_pkg::TOTAL_W-1] ? (~running_total + 1'b1)
                                                   : running_total;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_shift >= {1'b0, fill_count}) begin
        rem <= rem_diff[lcra_pkg::FILL_W-1:0];
        quo <= {quo[lcra_pkg::TOTAL_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[lcra_pkg::FILL_W-1:0];
        quo <= {quo[lcra_pkg::TOTAL_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      updated <= cmd.out_updated;
      average <= cmd.div_fix ? quo_signed[lcra_pkg::SAMPLE_W-1:0] : published_mean;
    end
  end

  always_comb begin
    sts.asleep   = asleep;
    sts.due      = (ms_since_report >= report_period);
    sts.div_last = (div_cnt == lcra_pkg::CNT_W'(lcra_pkg::TOTAL_W - 1));
  end

endmodule

[rtl/lcra_ctrl.sv]
// Controller of the load-cell ring average: input handshake, sequencing of
// commit and division, output valid. Uses lcra_pkg.
module lcra_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lcra_pkg::OP_W-1:0]   op,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lcra_pkg::cmd_t              cmd,
  input  lcra_pkg::sts_t              sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pub;
  logic       pub_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    pub_next   = pub;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            lcra_pkg::OP_TICK:  cmd.tick  = 1'b1;
            lcra_pkg::OP_SLEEP: cmd.sleep = 1'b1;
            lcra_pkg::OP_WAKE:  cmd.wake  = 1'b1;
            lcra_pkg::OP_SAMPLE: begin
              cmd.take_sample = 1'b1;
              pub_next        = 1'b0;
              state_next      = sts.asleep ? S_DONE : S_UPD;
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        cmd.commit = 1'b1;
        pub_next   = sts.due;
        state_next = sts.due ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_updated = pub;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pub       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pub   <= pub_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output valid rose outside the done state");

  a_commit_awake: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.asleep)
    else $error("ring commit while powered down");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_last) |=> (state == S_FIX))
    else $error("divider did not finish after its last step");

  a_upd_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $past(accept && op == lcra_pkg::OP_SAMPLE))
    else $error("commit without an accepted sample");

endmodule

[rtl/load_cell_ring_average.sv]
// Load-cell ring average: a tick, power-down or power-up transfer is handled in the idle state.
// A sample goes to the output register from the done state: directly when powered down, via
// the commit state when awake and no mean is due, and via commit, divider load, the divider steps
// (one quotient bit per cycle) and sign fix when it publishes; a stalled output adds its wait.
// The next input transfer is taken once the sample is in the output register.
// Synchronous active-high reset clears control state; the sample ring is not cleared.
module load_cell_ring_average (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lcra_pkg::OP_W-1:0]             op,
  input  logic signed [lcra_pkg::SAMPLE_W-1:0]  sample,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  updated,
  output logic signed [lcra_pkg::SAMPLE_W-1:0]  average,
  // report period register
  input  logic                                  cfg_we,
  input  logic [lcra_pkg::MS_W-1:0]             cfg_wdata
);

  lcra_pkg::cmd_t cmd;
  lcra_pkg::sts_t sts;

  // Sequence each transfer: decode op; for a sample, commit it when awake, run the divider
  // when the report period has elapsed, then hand off to the output register.
  lcra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the ring, running total, elapsed time and the published mean.
  lcra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .updated   (updated),
    .average   (average)
  );

endmodule
